// ===== hdl/agpr_pkg.sv =====
`timescale 1ns / 1ps

package agpr_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_ADD    = 2'd1;
   localparam op_type OP_FINISH = 2'd2;
   localparam op_type OP_READ   = 2'd3;

   localparam logic [15:0] SAT16_MAX = 16'hFFFF;
   localparam logic [3:0]  MAX_SHIFT = 4'd15;

   typedef struct packed {
      logic [15:0] pos;
      logic [15:0] cur;
   } entry_type;

   function automatic logic [16:0] grid_after(input logic [15:0] pos, input logic [3:0] shift);
      logic [16:0] grid_idx;
      grid_idx = ({1'b0, pos} >> shift) + 17'd1;
      return grid_idx << shift;
   endfunction

endpackage

// ===== hdl/agpr_ifs.sv =====
`timescale 1ns / 1ps

interface agpr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [31:0]        position;
   logic signed [31:0] motor_current;
   logic [7:0]         read_index;

   modport source (output valid, output op, output position, output motor_current,
                   output read_index, input ready);
   modport sink (input valid, input op, input position, input motor_current,
                 input read_index, output ready);
endinterface

interface agpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] entry_position;
   logic [15:0] entry_current;
   logic [6:0]  stored_entries;
   logic [15:0] grid_spacing;
   logic        recorded;

   modport source (output valid, output entry_position, output entry_current,
                   output stored_entries, output grid_spacing, output recorded,
                   input ready);
   modport sink (input valid, input entry_position, input entry_current,
                 input stored_entries, input grid_spacing, input recorded,
                 output ready);
endinterface

// ===== hdl/adaptive_grid_profile_recorder_top.sv =====
`timescale 1ns / 1ps

// Position/current profile recorder with adaptive grid decimation.
// req_chan carries one command per beat: clear, add sample, finish sample or
// read entry. rsp_chan returns exactly one beat per command with the read
// entry (zero unless a read hits a stored entry), the entry count, the grid
// spacing and the recorded flag.
// Commands run one at a time. A clear, an add below the next grid point and a
// finish at or below the last position go from EXEC straight to DONE; a read
// passes through RDWAIT and any other add or finish through STORE. The response
// is registered from DONE, and req_chan.ready is high again only in IDLE.
// An add or finish that would store into a full table first runs a compaction
// pass that walks the table through the single read port of the sample memory,
// doubling the spacing each pass and repeating while the table stays full and
// the spacing is below its maximum, then recomputes the grid point in CSTART;
// req_chan.ready stays low throughout.
// The response sits in an output register, so the next command is taken and
// processed while rsp_chan is stalled; only its own response waits for the
// register to empty. Synchronous reset empties the table, sets spacing to 1
// and drops any pending response; the sample memory itself is not cleared.
module adaptive_grid_profile_recorder_top #(
   parameter int DEPTH = 64
) (
   input logic            clock,
   input logic            reset,
   agpr_req_if.sink       req_chan,
   agpr_rsp_if.source     rsp_chan
);
   import agpr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_CSTART = 3'd3;
   localparam logic [2:0] S_CSCAN  = 3'd4;
   localparam logic [2:0] S_STORE  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [3:0]    shift_ff, shift_in;
   logic [16:0]   thr_ff, thr_in;
   logic [15:0]   last_pos_ff, last_pos_in;
   op_type        op_ff, op_in;
   logic [15:0]   pos_ff, pos_in;
   logic [15:0]   cur_ff, cur_in;
   logic [7:0]    idx_ff, idx_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          pipe_vld_ff, pipe_vld_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [15:0]   kept_pos_ff, kept_pos_in;
   logic          rec_ff, rec_in;
   logic [15:0]   epos_ff, epos_in;
   logic [15:0]   ecur_ff, ecur_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_epos_ff, rsp_epos_in;
   logic [15:0]   rsp_ecur_ff, rsp_ecur_in;
   logic [6:0]    rsp_count_ff, rsp_count_in;
   logic [15:0]   rsp_spacing_ff, rsp_spacing_in;
   logic          rsp_rec_ff, rsp_rec_in;

   logic          wr_pos_en, wr_cur_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;

   logic [31:0]   raw_cur, abs_cur;
   logic          idx_hit, keep, rsp_free;

   agpr_table #(.DEPTH(DEPTH)) u_table (
      .clock     (clock),
      .wr_pos_en (wr_pos_en),
      .wr_cur_en (wr_cur_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign raw_cur  = req_chan.motor_current;
   assign abs_cur  = raw_cur[31] ? (~raw_cur + 32'd1) : raw_cur;
   assign idx_hit  = ({1'b0, idx_ff} < 9'(fill_ff));
   assign keep     = pipe_vld_ff &&
                     ((kept_ff == '0) || (((rd_data.pos ^ kept_pos_ff) >> shift_ff) != 16'd0));
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      shift_in    = shift_ff;
      thr_in      = thr_ff;
      last_pos_in = last_pos_ff;
      op_in       = op_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      rd_idx_in   = rd_idx_ff;
      pipe_vld_in = 1'b0;
      kept_in     = kept_ff;
      kept_pos_in = kept_pos_ff;
      rec_in      = rec_ff;
      epos_in     = epos_ff;
      ecur_in     = ecur_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_epos_in    = rsp_epos_ff;
      rsp_ecur_in    = rsp_ecur_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_spacing_in = rsp_spacing_ff;
      rsp_rec_in     = rsp_rec_ff;

      wr_pos_en = 1'b0;
      wr_cur_en = 1'b0;
      wr_addr   = fill_ff[AW-1:0];
      wr_data   = '{pos: pos_ff, cur: cur_ff};
      rd_en     = 1'b0;
      rd_addr   = rd_idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.op;
               pos_in   = (|req_chan.position[31:16]) ? SAT16_MAX : req_chan.position[15:0];
               cur_in   = (|abs_cur[31:16]) ? SAT16_MAX : abs_cur[15:0];
               idx_in   = req_chan.read_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rec_in   = 1'b0;
            epos_in  = '0;
            ecur_in  = '0;
            state_in = S_DONE;
            case (op_ff)
               OP_CLEAR: begin
                  fill_in  = '0;
                  shift_in = '0;
                  thr_in   = '0;
               end
               OP_ADD: begin
                  if ({1'b0, pos_ff} >= thr_ff) begin
                     state_in = (fill_ff == DEPTH_C) ? S_CSTART : S_STORE;
                  end
               end
               OP_FINISH: begin
                  if (fill_ff != '0 && pos_ff == last_pos_ff) begin
                     wr_cur_en = 1'b1;
                     wr_addr   = AW'(fill_ff - CW'(1));
                     rec_in    = 1'b1;
                  end else if (fill_ff == '0 || pos_ff > last_pos_ff) begin
                     state_in = (fill_ff == DEPTH_C) ? S_CSTART : S_STORE;
                  end
               end
               OP_READ: begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_hit ? idx_ff[AW-1:0] : '0;
                  state_in = S_RDWAIT;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RDWAIT: begin
            if (idx_hit) begin
               epos_in = rd_data.pos;
               ecur_in = rd_data.cur;
            end
            state_in = S_DONE;
         end
         S_CSTART: begin
            if (fill_ff == DEPTH_C && shift_ff < MAX_SHIFT) begin
               shift_in  = shift_ff + 4'd1;
               rd_idx_in = '0;
               kept_in   = '0;
               state_in  = S_CSCAN;
            end else begin
               thr_in   = grid_after(last_pos_ff, shift_ff);
               state_in = S_STORE;
            end
         end
         S_CSCAN: begin
            if (rd_idx_ff < fill_ff) begin
               rd_en       = 1'b1;
               rd_idx_in   = rd_idx_ff + CW'(1);
               pipe_vld_in = 1'b1;
            end
            if (keep) begin
               wr_pos_en   = 1'b1;
               wr_cur_en   = 1'b1;
               wr_addr     = kept_ff[AW-1:0];
               wr_data     = rd_data;
               kept_in     = kept_ff + CW'(1);
               kept_pos_in = rd_data.pos;
            end
            if (!pipe_vld_ff && rd_idx_ff == fill_ff) begin
               fill_in     = kept_ff;
               last_pos_in = kept_pos_ff;
               state_in    = S_CSTART;
            end
         end
         S_STORE: begin
            state_in = S_DONE;
            if (!(op_ff == OP_ADD && {1'b0, pos_ff} < thr_ff) && fill_ff < DEPTH_C) begin
               wr_pos_en   = 1'b1;
               wr_cur_en   = 1'b1;
               fill_in     = fill_ff + CW'(1);
               thr_in      = grid_after(pos_ff, shift_ff);
               last_pos_in = pos_ff;
               rec_in      = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_epos_in    = epos_ff;
               rsp_ecur_in    = ecur_ff;
               rsp_count_in   = 7'(fill_ff);
               rsp_spacing_in = 16'd1 << shift_ff;
               rsp_rec_in     = rec_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         shift_ff     <= '0;
         thr_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         shift_ff     <= shift_in;
         thr_ff       <= thr_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_pos_ff    <= last_pos_in;
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      idx_ff         <= idx_in;
      rd_idx_ff      <= rd_idx_in;
      kept_ff        <= kept_in;
      kept_pos_ff    <= kept_pos_in;
      rec_ff         <= rec_in;
      epos_ff        <= epos_in;
      ecur_ff        <= ecur_in;
      rsp_epos_ff    <= rsp_epos_in;
      rsp_ecur_ff    <= rsp_ecur_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_spacing_ff <= rsp_spacing_in;
      rsp_rec_ff     <= rsp_rec_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.entry_position = rsp_epos_ff;
   assign rsp_chan.entry_current  = rsp_ecur_ff;
   assign rsp_chan.stored_entries = rsp_count_ff;
   assign rsp_chan.grid_spacing   = rsp_spacing_ff;
   assign rsp_chan.recorded       = rsp_rec_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("entry count exceeds table depth");

   a_scan_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CSCAN) |-> (fill_ff == DEPTH_C))
      else $error("compaction running on a table that is not full");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CSCAN) |-> (kept_ff <= rd_idx_ff))
      else $error("compaction write index passed read index");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == OP_CLEAR) |=>
         (fill_ff == '0 && shift_ff == '0 && thr_ff == '0))
      else $error("clear left table state behind");
`endif

endmodule

// ===== hdl/agpr_table.sv =====
`timescale 1ns / 1ps

module agpr_table #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_pos_en,
   input  logic                     wr_cur_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  agpr_pkg::entry_type      wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output agpr_pkg::entry_type      rd_data
);
   import agpr_pkg::*;

   logic [15:0] pos_mem [DEPTH];
   logic [15:0] cur_mem [DEPTH];
   entry_type   rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_pos_en) begin
         pos_mem[wr_addr] <= wr_data.pos;
      end
      if (wr_cur_en) begin
         cur_mem[wr_addr] <= wr_data.cur;
      end
      if (rd_en) begin
         rd_data_ff.pos <= pos_mem[rd_addr];
         rd_data_ff.cur <= cur_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/agpr_profile_checker.sv =====
`timescale 1ns / 1ps

module agpr_profile_checker #(
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   agpr_req_if  req_chan,
   agpr_rsp_if  rsp_chan,
   output int   fault_total,
   output int   replies_pending
);

   import agpr_pkg::*;

   localparam int MAX_GRID = 1 << MAX_SHIFT;

   typedef struct packed {
      logic [15:0] epos;
      logic [15:0] ecur;
      logic [6:0]  count;
      logic [15:0] spacing;
      logic        rec;
   } profile_reply_type;

   profile_reply_type expected_replies[$];

   logic [15:0] table_pos [DEPTH];
   logic [15:0] table_cur [DEPTH];
   int          table_fill = 0;
   int          grid_step = 1;
   int          grid_next = 0;
   int          faults_seen = 0;

   function automatic logic [15:0] clamp_position(logic [31:0] raw);
      return (raw > 32'h0000_FFFF) ? SAT16_MAX : raw[15:0];
   endfunction

   function automatic logic [15:0] current_magnitude(logic [31:0] raw);
      logic [31:0] mag;
      mag = raw[31] ? (~raw + 32'd1) : raw;
      return (mag > 32'h0000_FFFF) ? SAT16_MAX : mag[15:0];
   endfunction

   function automatic int next_grid_point(int p);
      return (p / grid_step + 1) * grid_step;
   endfunction

   function automatic void compact_profile();
      int kept;
      while (table_fill == DEPTH && grid_step < MAX_GRID) begin
         kept = 0;
         grid_step = grid_step * 2;
         for (int i = 0; i < table_fill; i++) begin
            if (kept == 0 ||
                int'(table_pos[i]) / grid_step != int'(table_pos[kept - 1]) / grid_step) begin
               table_pos[kept] = table_pos[i];
               table_cur[kept] = table_cur[i];
               kept++;
            end
         end
         table_fill = kept;
      end
      grid_next = (table_fill != 0) ? next_grid_point(table_pos[table_fill - 1]) : 0;
   endfunction

   function automatic bit append_sample(logic [15:0] pos, logic [15:0] cur);
      if (table_fill >= DEPTH)
         return 1'b0;
      table_pos[table_fill] = pos;
      table_cur[table_fill] = cur;
      table_fill++;
      grid_next = next_grid_point(pos);
      return 1'b1;
   endfunction

   function automatic profile_reply_type predict_profile_step(op_type op,
                                                              logic [31:0] position,
                                                              logic [31:0] current,
                                                              logic [7:0] index);
      profile_reply_type r;
      logic [15:0]       pos;
      logic [15:0]       cur;
      bit                admit;
      r = '0;
      pos = clamp_position(position);
      cur = current_magnitude(current);
      admit = 1'b1;
      case (op)
         OP_CLEAR: begin
            table_fill = 0;
            grid_step = 1;
            grid_next = 0;
         end
         OP_ADD: begin
            if (int'(pos) >= grid_next) begin
               if (table_fill == DEPTH) begin
                  compact_profile();
                  admit = int'(pos) >= grid_next;
               end
               if (admit)
                  r.rec = append_sample(pos, cur);
            end
         end
         OP_FINISH: begin
            if (table_fill > 0 && pos < table_pos[table_fill - 1]) begin
               admit = 1'b0;
            end else if (table_fill > 0 && pos == table_pos[table_fill - 1]) begin
               table_cur[table_fill - 1] = cur;
               r.rec = 1'b1;
               admit = 1'b0;
            end
            if (admit) begin
               if (table_fill == DEPTH)
                  compact_profile();
               r.rec = append_sample(pos, cur);
            end
         end
         OP_READ: begin
            if (int'(index) < table_fill) begin
               r.epos = table_pos[index];
               r.ecur = table_cur[index];
            end
         end
         default: begin
         end
      endcase
      r.count = table_fill[6:0];
      r.spacing = grid_step[15:0];
      return r;
   endfunction

   task automatic report_fault(input string what, input int got, input int want);
      faults_seen++;
      $display("%0t ns profile reply %s: got 0x%0h, expected 0x%0h",
               $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch_channels
      profile_reply_type want;
      if (reset) begin
         table_fill = 0;
         grid_step = 1;
         grid_next = 0;
         expected_replies.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_replies.size() == 0) begin
               report_fault("beat with no command outstanding", 0, 0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_chan.entry_position !== want.epos)
                  report_fault("entry_position", rsp_chan.entry_position, want.epos);
               if (rsp_chan.entry_current !== want.ecur)
                  report_fault("entry_current", rsp_chan.entry_current, want.ecur);
               if (rsp_chan.stored_entries !== want.count)
                  report_fault("stored_entries", rsp_chan.stored_entries, want.count);
               if (rsp_chan.grid_spacing !== want.spacing)
                  report_fault("grid_spacing", rsp_chan.grid_spacing, want.spacing);
               if (rsp_chan.recorded !== want.rec)
                  report_fault("recorded", rsp_chan.recorded, want.rec);
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_replies.push_back(predict_profile_step(req_chan.op, req_chan.position,
                                                            req_chan.motor_current,
                                                            req_chan.read_index));
      end
      fault_total <= faults_seen;
      replies_pending <= expected_replies.size();
   end

endmodule

// ===== tb/tb_adaptive_grid_profile_recorder_top.sv =====
`timescale 1ns / 1ps

module tb_adaptive_grid_profile_recorder_top;

   import agpr_pkg::*;

   localparam int PROFILE_DEPTH = 64;
   localparam int QUIET_LIMIT = 10000;
   localparam int PHASE_BEATS = 135;

   logic clock;
   logic reset;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   beats_sent = 0;
   int   quiet_cycles = 0;
   int   reply_faults;
   int   replies_outstanding;

   agpr_req_if req_chan ();
   agpr_rsp_if rsp_chan ();

   adaptive_grid_profile_recorder_top #(
      .DEPTH(PROFILE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   agpr_profile_checker #(
      .DEPTH(PROFILE_DEPTH)
   ) profile_check (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .fault_total(reply_faults),
      .replies_pending(replies_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("adaptive_grid_profile_recorder_top verification failed");
            $finish;
         end
      end
   end

   function automatic logic [31:0] pick_current();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 70000);
         2: return -$urandom_range(0, 70000);
         default: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_0001;
               default: return 32'hFFFF_0000;
            endcase
         end
      endcase
   endfunction

   // hold valid across back-to-back beats; drop it only for an idle gap
   task automatic send_command(input op_type op, input logic [31:0] position,
                               input logic [31:0] current, input logic [7:0] index);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.position <= position;
      req_chan.motor_current <= current;
      req_chan.read_index <= index;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      beats_sent++;
   endtask

   initial begin
      int cursor;
      int step_max;
      int pick;
      int phase_target;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op <= OP_CLEAR;
      req_chan.position <= '0;
      req_chan.motor_current <= '0;
      req_chan.read_index <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_command(OP_CLEAR, 32'd0, 32'd0, 8'd0);
      send_command(OP_READ, 32'd0, 32'd0, 8'd0);
      send_command(OP_FINISH, 32'd40, 32'hFFFF_FFF9, 8'd0);
      send_command(OP_ADD, 32'd40, 32'd5, 8'd0);
      send_command(OP_ADD, 32'd41, 32'h7FFF_FFFF, 8'd0);
      send_command(OP_FINISH, 32'd12, 32'd9, 8'd0);
      send_command(OP_FINISH, 32'd41, 32'h8000_0000, 8'd0);
      send_command(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_8000, 8'd0);
      send_command(OP_ADD, 32'h0001_0000, 32'd1, 8'd0);
      send_command(OP_FINISH, 32'hFFFF_FFFF, 32'd0, 8'd0);
      send_command(OP_FINISH, 32'h0000_FFFE, 32'd3, 8'd0);
      for (int k = 0; k < 5; k++)
         send_command(OP_READ, $urandom, $urandom, k[7:0]);
      send_command(OP_READ, 32'd0, 32'd0, 8'd255);
      send_command(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
      send_command(OP_ADD, 32'd0, 32'd0, 8'd0);
      send_command(OP_ADD, 32'd0, 32'd7, 8'd0);
      send_command(OP_READ, 32'd0, 32'd0, 8'd0);
      send_command(OP_READ, 32'd0, 32'd0, 8'd1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase

         // spread finishes, then crowd the top of the range until spacing tops out
         if (phase == 0) begin
            send_command(OP_CLEAR, $urandom, $urandom, $urandom);
            for (int k = 0; k < PROFILE_DEPTH; k++)
               send_command(OP_FINISH, k * 1000 + $urandom_range(0, 999), pick_current(),
                            $urandom);
            cursor = 65000;
            repeat (500) begin
               if ($urandom_range(99) < 5) begin
                  send_command(OP_READ, $urandom, $urandom, $urandom_range(0, 63));
               end else begin
                  send_command(OP_FINISH, cursor, pick_current(), $urandom);
                  cursor++;
               end
            end
            repeat (6)
               send_command(OP_ADD, cursor + $urandom_range(0, 40), pick_current(), $urandom);
            repeat (3)
               send_command(OP_FINISH, 32'hFFFF_FFFF, pick_current(), $urandom);
            for (int k = 0; k < 4; k++)
               send_command(OP_READ, $urandom, $urandom, 8'(k * 21));
         end

         phase_target = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_target) begin
            if ($urandom_range(99) < 78) begin
               if ($urandom_range(99) < 85)
                  send_command(OP_CLEAR, $urandom, $urandom, $urandom);
               cursor = $urandom_range(0, 300);
               case ($urandom_range(3))
                  0: step_max = 1;
                  1: step_max = 8;
                  2: step_max = 90;
                  default: step_max = 1500;
               endcase
               repeat ($urandom_range(50, 160)) begin
                  pick = $urandom_range(99);
                  if (pick < 72) begin
                     cursor += $urandom_range(0, step_max);
                     send_command(OP_ADD, cursor, pick_current(), $urandom);
                  end else if (pick < 82) begin
                     cursor = cursor + $urandom_range(0, 2) - 1;
                     if (cursor < 0)
                        cursor = 0;
                     send_command(OP_FINISH, cursor, pick_current(), $urandom);
                  end else if (pick < 95) begin
                     send_command(OP_READ, $urandom, pick_current(), $urandom_range(0, 66));
                  end else begin
                     send_command(OP_READ, $urandom, $urandom, $urandom_range(0, 255));
                  end
               end
            end else begin
               repeat ($urandom_range(4, 24))
                  send_command(op_type'($urandom_range(0, 3)),
                               $urandom_range(1) ? $urandom : $urandom_range(0, 32'h1FFFF),
                               pick_current(), $urandom);
            end
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (replies_outstanding != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (reply_faults == 0)
         $display("adaptive_grid_profile_recorder_top verification clean");
      else
         $display("adaptive_grid_profile_recorder_top verification failed");
      $finish;
   end

endmodule
